FILE: rtl/ttv_pkg.sv
package ttv_pkg;

  localparam int POSITION_BITS_DEF = 24;
  localparam int TEXCOORD_BITS_DEF = 20;
  localparam int TANGENT_BITS_DEF  = 16;

  // magnitudes are brought down to this many bits before squaring
  localparam int NORM_BITS = 30;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ZERO_DET = 2'd1,
    STATUS_ZERO_TAN = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DET_A,
    S_DET_B,
    S_DET_C,
    S_TAN_A,
    S_TAN_B,
    S_TAN_C,
    S_SHIFT,
    S_SQ_MUL,
    S_SQ_ACC,
    S_SQRT,
    S_DIV_INIT,
    S_DIV_STEP,
    S_DIV_DONE,
    S_WRITE
  } state_t;

endpackage

FILE: rtl/triangle_tangent_vector_top.sv
// channel   direction  handshake                    payload
// vertex    in         vertex_valid / vertex_stall  pos_x pos_y pos_z tex_u tex_v
// tangent   out        tangent_valid / tangent_stall tangent_x tangent_y tangent_z status
//
// First and second vertex of a triangle are taken without a stall while idle.
// Third vertex: the work is set by the shared multiplier sequence, the bit-serial
// right shift, the 31-step square root and three 16-step restoring divisions
// (at default widths), plus any time the write-back is held; a zero UV determinant
// or a zero tangent ends the work early.
// Reset (rst, synchronous) clears the corner count, sequencer and output valid.
// vertex_stall is high while a triangle is being worked on, write-back included;
// tangent_stall holds the write-back, but next-triangle vertices are taken once it loads.
module triangle_tangent_vector_top #(
  parameter int POSITION_BITS = ttv_pkg::POSITION_BITS_DEF,
  parameter int TEXCOORD_BITS = ttv_pkg::TEXCOORD_BITS_DEF,
  parameter int TANGENT_BITS  = ttv_pkg::TANGENT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            vertex_valid,
  output logic                            vertex_stall,
  input  logic signed [POSITION_BITS-1:0] pos_x,
  input  logic signed [POSITION_BITS-1:0] pos_y,
  input  logic signed [POSITION_BITS-1:0] pos_z,
  input  logic signed [TEXCOORD_BITS-1:0] tex_u,
  input  logic signed [TEXCOORD_BITS-1:0] tex_v,
  output logic                            tangent_valid,
  input  logic                            tangent_stall,
  output logic signed [TANGENT_BITS-1:0]  tangent_x,
  output logic signed [TANGENT_BITS-1:0]  tangent_y,
  output logic signed [TANGENT_BITS-1:0]  tangent_z,
  output logic [1:0]                      status
);

  localparam int NB    = ttv_pkg::NORM_BITS;
  localparam int EW    = POSITION_BITS + 1;
  localparam int UW    = TEXCOORD_BITS + 1;
  localparam int MA    = (UW > NB + 1) ? UW : NB + 1;
  localparam int MB    = (EW > NB + 1) ? EW : NB + 1;
  localparam int PW    = MA + MB;
  localparam int MAG_W = (TEXCOORD_BITS + POSITION_BITS + 2 > NB + 1) ?
                         TEXCOORD_BITS + POSITION_BITS + 2 : NB + 1;
  localparam int SUM_W = 2 * NB + 2;
  localparam int LEN_W = NB + 1;
  localparam int NUM_W = NB + TANGENT_BITS;
  localparam int DCNT_W = $clog2(TANGENT_BITS);

  ttv_pkg::state_t  state, state_next;
  ttv_pkg::status_t res_status;

  logic [1:0] corner_count;
  logic [1:0] idx;

  logic signed [POSITION_BITS-1:0] held_pos_x [2];
  logic signed [POSITION_BITS-1:0] held_pos_y [2];
  logic signed [POSITION_BITS-1:0] held_pos_z [2];
  logic signed [TEXCOORD_BITS-1:0] held_u [2];
  logic signed [TEXCOORD_BITS-1:0] held_v [2];

  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [UW-1:0] du1, dv1, du2, dv2;

  logic signed [MA-1:0] ma;
  logic signed [MB-1:0] mb;
  logic signed [PW-1:0] prod, acc;
  logic signed [PW:0]   diff, diff_abs;

  logic              dneg;
  logic [2:0]        cneg;
  logic [MAG_W-1:0]  mag [3];
  logic [MAG_W-1:0]  mag_or;
  logic [NB:0]       sq_op;

  logic [SUM_W-1:0]  sq_n, sq_r, sq_bit, sq_trial, sq_r_next;
  logic              sq_ge;
  logic [LEN_W-1:0]  len;

  logic [LEN_W-1:0]        rem;
  logic [TANGENT_BITS-1:0] low;
  logic [DCNT_W-1:0]       dcnt;
  logic [NUM_W-1:0]        num;
  logic [LEN_W:0]          div_trial;
  logic                    div_ge;
  logic [TANGENT_BITS-1:0] sat;

  logic signed [TANGENT_BITS-1:0] res [3];

  logic vertex_take;
  logic out_load;

  assign vertex_take = vertex_valid && !vertex_stall;
  assign out_load    = (state == ttv_pkg::S_WRITE) && (!tangent_valid || !tangent_stall);

  // shared multiplier operands
  assign sq_op = {1'b0, mag[idx][NB-1:0]};

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      ttv_pkg::S_DET_A: begin
        ma = MA'(du1);
        mb = MB'(dv2);
      end
      ttv_pkg::S_DET_B: begin
        ma = MA'(du2);
        mb = MB'(dv1);
      end
      ttv_pkg::S_TAN_A: begin
        ma = MA'(dv2);
        mb = MB'(e1[idx]);
      end
      ttv_pkg::S_TAN_B: begin
        ma = MA'(dv1);
        mb = MB'(e2[idx]);
      end
      ttv_pkg::S_SQ_MUL: begin
        ma = MA'(sq_op);
        mb = MB'(sq_op);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign diff     = (PW + 1)'(acc) - (PW + 1)'(prod);
  assign diff_abs = diff[PW] ? -diff : diff;
  assign mag_or   = mag[0] | mag[1] | mag[2];

  assign sq_trial  = sq_r + sq_bit;
  assign sq_ge     = sq_n >= sq_trial;
  assign sq_r_next = sq_ge ? ((sq_r >> 1) + sq_bit) : (sq_r >> 1);

  assign num = NUM_W'({mag[idx][NB-1:0], {(TANGENT_BITS - 1){1'b0}}})
             + NUM_W'(len[LEN_W-1:1]);
  assign div_trial = {rem, low[TANGENT_BITS-1]};
  assign div_ge    = div_trial >= {1'b0, len};
  assign sat = low[TANGENT_BITS-1] ? {1'b0, {(TANGENT_BITS - 1){1'b1}}} : low;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttv_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    vertex_stall = (state != ttv_pkg::S_IDLE);
    unique case (state)
      ttv_pkg::S_IDLE: begin
        if (vertex_valid && corner_count[1]) state_next = ttv_pkg::S_DET_A;
      end
      ttv_pkg::S_DET_A: state_next = ttv_pkg::S_DET_B;
      ttv_pkg::S_DET_B: state_next = ttv_pkg::S_DET_C;
      ttv_pkg::S_DET_C: begin
        state_next = (diff == '0) ? ttv_pkg::S_WRITE : ttv_pkg::S_TAN_A;
      end
      ttv_pkg::S_TAN_A: state_next = ttv_pkg::S_TAN_B;
      ttv_pkg::S_TAN_B: state_next = ttv_pkg::S_TAN_C;
      ttv_pkg::S_TAN_C: begin
        state_next = (idx == 2'd2) ? ttv_pkg::S_SHIFT : ttv_pkg::S_TAN_A;
      end
      ttv_pkg::S_SHIFT: begin
        priority if (mag_or == '0) state_next = ttv_pkg::S_WRITE;
        else if (!(|mag_or[MAG_W-1:NB])) state_next = ttv_pkg::S_SQ_MUL;
        else state_next = ttv_pkg::S_SHIFT;
      end
      ttv_pkg::S_SQ_MUL: state_next = ttv_pkg::S_SQ_ACC;
      ttv_pkg::S_SQ_ACC: begin
        state_next = (idx == 2'd2) ? ttv_pkg::S_SQRT : ttv_pkg::S_SQ_MUL;
      end
      ttv_pkg::S_SQRT: begin
        if (sq_bit[0]) state_next = ttv_pkg::S_DIV_INIT;
      end
      ttv_pkg::S_DIV_INIT: state_next = ttv_pkg::S_DIV_STEP;
      ttv_pkg::S_DIV_STEP: begin
        if (dcnt == DCNT_W'(TANGENT_BITS - 1)) state_next = ttv_pkg::S_DIV_DONE;
      end
      ttv_pkg::S_DIV_DONE: begin
        state_next = (idx == 2'd2) ? ttv_pkg::S_WRITE : ttv_pkg::S_DIV_INIT;
      end
      ttv_pkg::S_WRITE: begin
        if (!tangent_valid || !tangent_stall) state_next = ttv_pkg::S_IDLE;
      end
      default: state_next = ttv_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      corner_count  <= '0;
      idx           <= '0;
      tangent_valid <= 1'b0;
    end else begin
      if (vertex_take) begin
        corner_count <= corner_count[1] ? 2'd0 : corner_count + 2'd1;
      end
      unique case (state)
        ttv_pkg::S_TAN_C, ttv_pkg::S_SQ_ACC, ttv_pkg::S_DIV_DONE: begin
          idx <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
        end
        ttv_pkg::S_IDLE: idx <= '0;
        default: idx <= idx;
      endcase
      if (out_load) begin
        tangent_valid <= 1'b1;
      end else if (!tangent_stall) begin
        tangent_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    unique case (state)
      ttv_pkg::S_IDLE: begin
        if (vertex_take && !corner_count[1]) begin
          held_pos_x[corner_count[0]] <= pos_x;
          held_pos_y[corner_count[0]] <= pos_y;
          held_pos_z[corner_count[0]] <= pos_z;
          held_u[corner_count[0]]     <= tex_u;
          held_v[corner_count[0]]     <= tex_v;
        end else if (vertex_take) begin
          e1[0] <= EW'(held_pos_x[1]) - EW'(held_pos_x[0]);
          e1[1] <= EW'(held_pos_y[1]) - EW'(held_pos_y[0]);
          e1[2] <= EW'(held_pos_z[1]) - EW'(held_pos_z[0]);
          e2[0] <= EW'(pos_x) - EW'(held_pos_x[0]);
          e2[1] <= EW'(pos_y) - EW'(held_pos_y[0]);
          e2[2] <= EW'(pos_z) - EW'(held_pos_z[0]);
          du1   <= UW'(held_u[1]) - UW'(held_u[0]);
          dv1   <= UW'(held_v[1]) - UW'(held_v[0]);
          du2   <= UW'(tex_u) - UW'(held_u[0]);
          dv2   <= UW'(tex_v) - UW'(held_v[0]);
        end
      end
      ttv_pkg::S_DET_B, ttv_pkg::S_TAN_B: acc <= prod;
      ttv_pkg::S_DET_C: begin
        dneg       <= diff[PW];
        res_status <= (diff == '0) ? ttv_pkg::STATUS_ZERO_DET : ttv_pkg::STATUS_OK;
      end
      ttv_pkg::S_TAN_C: begin
        mag[idx]  <= diff_abs[MAG_W-1:0];
        cneg[idx] <= diff[PW];
      end
      ttv_pkg::S_SHIFT: begin
        sq_n <= '0;
        if (mag_or == '0) begin
          res_status <= ttv_pkg::STATUS_ZERO_TAN;
        end else if (|mag_or[MAG_W-1:NB]) begin
          mag[0] <= mag[0] >> 1;
          mag[1] <= mag[1] >> 1;
          mag[2] <= mag[2] >> 1;
        end
      end
      ttv_pkg::S_SQ_ACC: begin
        sq_n   <= sq_n + prod[SUM_W-1:0];
        sq_r   <= '0;
        sq_bit <= SUM_W'(1) << (SUM_W - 2);
      end
      ttv_pkg::S_SQRT: begin
        if (sq_ge) sq_n <= sq_n - sq_trial;
        sq_r   <= sq_r_next;
        sq_bit <= sq_bit >> 2;
        len    <= sq_r_next[LEN_W-1:0];
      end
      ttv_pkg::S_DIV_INIT: begin
        rem  <= LEN_W'(num[NUM_W-1:TANGENT_BITS]);
        low  <= num[TANGENT_BITS-1:0];
        dcnt <= '0;
      end
      ttv_pkg::S_DIV_STEP: begin
        rem  <= div_ge ? LEN_W'(div_trial - {1'b0, len}) : div_trial[LEN_W-1:0];
        low  <= {low[TANGENT_BITS-2:0], div_ge};
        dcnt <= dcnt + DCNT_W'(1);
      end
      ttv_pkg::S_DIV_DONE: begin
        res[idx] <= (cneg[idx] ^ dneg) ? -sat : sat;
      end
      ttv_pkg::S_WRITE: begin
        if (out_load) begin
          tangent_x <= (res_status == ttv_pkg::STATUS_OK) ? res[0] : '0;
          tangent_y <= (res_status == ttv_pkg::STATUS_OK) ? res[1] : '0;
          tangent_z <= (res_status == ttv_pkg::STATUS_OK) ? res[2] : '0;
          status    <= res_status;
        end
      end
      default: begin
      end
    endcase
  end

  a_corner_range: assert property (@(posedge clk) disable iff (rst)
    corner_count != 2'd3)
    else $error("corner count out of range");

  a_busy_corner: assert property (@(posedge clk) disable iff (rst)
    (state != ttv_pkg::S_IDLE) |-> (corner_count == 2'd0))
    else $error("vertex held while a triangle is in flight");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ttv_pkg::S_DIV_INIT) |-> (len != '0))
    else $error("zero length reached the divider");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ttv_pkg::S_DIV_STEP) |-> (rem < len))
    else $error("divider remainder not below divisor");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (tangent_valid && (status != ttv_pkg::STATUS_OK)) |->
      (tangent_x == '0 && tangent_y == '0 && tangent_z == '0))
    else $error("failed transaction carries a nonzero tangent");

endmodule
